### src/bps_pkg.sv
// bps_pkg: shared types and constants for the Bezier path sampler.
// Used by the top level and the shift-subtract recurrence unit.
package bps_pkg;

  // Segment sample count: 6 bits, saturates at MAX_SAMPLES
  localparam int unsigned NBITS       = 6;
  localparam int unsigned MAX_SAMPLES = 63;

  // Configuration register indexes and reset values
  localparam logic        REG_SPACING   = 1'b0;
  localparam logic        REG_LIMIT     = 1'b1;
  localparam logic [31:0] SPACING_RESET = 32'h0001_0000;
  localparam logic [15:0] LIMIT_RESET   = 16'd20;
  localparam logic [15:0] LIMIT_MIN     = 16'd4;

  // Recurrence unit widths and step counts
  localparam int unsigned REM_W  = 35;
  localparam int unsigned ACC_W  = 66;
  localparam int unsigned ROOT_W = 33;
  localparam logic [5:0]  SQRT_STEPS = 6'd33;
  localparam logic [5:0]  QDIV_STEPS = 6'd32;
  localparam logic [5:0]  NDIV_STEPS = 6'(NBITS);

  typedef struct packed {
    logic              start;
    logic              sqrt_mode;
    logic [5:0]        steps;
    logic [REM_W-1:0]  rem_init;
    logic [ACC_W-1:0]  acc_init;
    logic [ROOT_W-1:0] den;
  } rec_cmd_t;

endpackage

### src/bps_rec.sv
// bps_rec: shared shift-subtract unit, one bit per cycle.
// Does restoring square root (2 radicand bits a step) or division (1 bit a step).
// Depends on bps_pkg.
module bps_rec import bps_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  rec_cmd_t          cmd,
  output logic              done,
  output logic [ROOT_W-1:0] result
);

  logic [REM_W-1:0]  rem;
  logic [ACC_W-1:0]  acc;
  logic [ROOT_W-1:0] root;
  logic [ROOT_W-1:0] den;
  logic              sqrt_mode;
  logic [5:0]        cnt;
  logic [REM_W+1:0]  shifted;
  logic [REM_W+1:0]  trial;
  logic [REM_W+1:0]  diff;
  logic              ge;

  always_comb begin
    if (sqrt_mode) begin
      shifted = {rem, acc[ACC_W-1 -: 2]};
      trial   = {2'b00, root, 2'b01};
    end else begin
      shifted = {1'b0, rem, acc[ACC_W-1]};
      trial   = (REM_W+2)'(den);
    end
    ge   = shifted >= trial;
    diff = shifted - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cnt  <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (cmd.start) begin
        cnt <= cmd.steps;
      end else if (cnt != '0) begin
        cnt  <= cnt - 6'd1;
        done <= (cnt == 6'd1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      rem       <= cmd.rem_init;
      acc       <= cmd.acc_init;
      root      <= '0;
      den       <= cmd.den;
      sqrt_mode <= cmd.sqrt_mode;
    end else if (cnt != '0) begin
      rem  <= ge ? diff[REM_W-1:0] : shifted[REM_W-1:0];
      acc  <= sqrt_mode ? (acc << 2) : (acc << 1);
      root <= {root[ROOT_W-2:0], ge};
    end
  end

  assign result = root;

endmodule

### src/bezier_path_sampler.sv
// Pass-through points are shown from the cycle after the path_end transaction, one
// per cycle while out_ready is high. A segment runs three 33-step square roots, then
// per sample six coefficient multiplies, eight MAC multiplies and two 32-step
// divisions, for n+1 samples.
// Throughput: one item at a time; in_ready is low while a segment or a short path drains.
// Waypoints that give no result leave the sequencer idle, so in_ready stays high.
// Reset (rst, synchronous): configuration registers to reset values, waypoint count 0, sequencer idle.
module bezier_path_sampler import bps_pkg::*; (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic signed [31:0] point_x,
  input  logic signed [31:0] point_y,
  input  logic               path_end,
  output logic               out_valid,
  input  logic               out_ready,
  output logic signed [31:0] sample_x,
  output logic signed [31:0] sample_y,
  output logic               run_last,
  input  logic               cfg_wen,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data
);

  typedef enum logic [19:0] {
    ST_IDLE      = 20'h00001,
    ST_PASS      = 20'h00002,
    ST_SQX       = 20'h00004,
    ST_SQY       = 20'h00008,
    ST_ROOT_GO   = 20'h00010,
    ST_ROOT_WAIT = 20'h00020,
    ST_NCNT      = 20'h00040,
    ST_NWAIT     = 20'h00080,
    ST_CO1       = 20'h00100,
    ST_CO2       = 20'h00200,
    ST_CO3       = 20'h00400,
    ST_CO4       = 20'h00800,
    ST_CO5       = 20'h01000,
    ST_CO6       = 20'h02000,
    ST_CO7       = 20'h04000,
    ST_MAC_MUL   = 20'h08000,
    ST_MAC_ADD   = 20'h10000,
    ST_DIV_GO    = 20'h20000,
    ST_DIV_WAIT  = 20'h40000,
    ST_OUT       = 20'h80000
  } state_t;

  state_t state;

  logic [31:0] spacing;
  logic [15:0] limit;
  logic [15:0] count;
  logic [1:0]  phase;

  logic signed [31:0] held_x [3];
  logic signed [31:0] held_y [3];
  logic signed [31:0] seg_x  [4];
  logic signed [31:0] seg_y  [4];

  logic [1:0]  pidx;
  logic [1:0]  plast;
  logic [1:0]  sidx;
  logic [63:0] sqx;
  logic [34:0] len;
  logic [NBITS-1:0] n;
  logic [NBITS-1:0] j;
  logic [11:0] aa;
  logic [11:0] tt;
  logic [17:0] coef [4];
  logic [17:0] den;
  logic [2:0]  m;
  logic signed [49:0] acc;
  logic        neg;
  logic signed [31:0] res_x;
  logic signed [31:0] res_y;

  logic signed [32:0] mul_a;
  logic signed [32:0] mul_b;
  logic signed [65:0] prod;

  rec_cmd_t          rec_cmd;
  logic              rec_done;
  logic [ROOT_W-1:0] rec_result;

  logic [15:0]        eff_limit;
  logic [NBITS-1:0]   a_val;
  logic signed [32:0] dx;
  logic signed [32:0] dy;
  logic [35:0]        n_num;
  logic [32:0]        n_den;
  logic               n_sat;
  logic [NBITS-1:0]   q6;
  logic [49:0]        mag;
  logic [49:0]        div_num;
  logic signed [31:0] signed_q;
  logic               rotate;

  bps_rec u_rec (
    .clk    (clk),
    .rst    (rst),
    .cmd    (rec_cmd),
    .done   (rec_done),
    .result (rec_result)
  );

  assign eff_limit = (limit < LIMIT_MIN) ? LIMIT_MIN : limit;
  assign a_val     = n - j;
  assign dx        = 33'(seg_x[1]) - 33'(seg_x[0]);
  assign dy        = 33'(seg_y[1]) - 33'(seg_y[0]);
  assign n_num     = {len, 1'b0} + 36'(spacing);
  assign n_den     = {spacing, 1'b0};
  assign n_sat     = 39'(n_num) >= {n_den, 6'b0};
  assign q6        = rec_result[NBITS-1:0];
  assign mag       = acc[49] ? 50'(-acc) : 50'(acc);
  assign div_num   = mag + 50'(den[17:1]);
  assign signed_q  = neg ? -$signed(rec_result[31:0]) : $signed(rec_result[31:0]);
  assign rotate    = (state == ST_SQY) || (state == ST_NCNT) || (state == ST_MAC_MUL);

  assign in_ready  = (state == ST_IDLE);
  assign out_valid = (state == ST_PASS) || (state == ST_OUT);
  assign sample_x  = (state == ST_PASS) ? held_x[pidx] : res_x;
  assign sample_y  = (state == ST_PASS) ? held_y[pidx] : res_y;
  assign run_last  = (state == ST_PASS) ? (pidx == plast) : (j == n);

  // Shared multiplier operand select
  always_comb begin
    case (state)
      ST_SQX: begin
        mul_a = dx;
        mul_b = dx;
      end
      ST_SQY: begin
        mul_a = dy;
        mul_b = dy;
      end
      ST_CO1: begin
        mul_a = $signed(33'(a_val));
        mul_b = $signed(33'(a_val));
      end
      ST_CO2: begin
        mul_a = $signed(33'(j));
        mul_b = $signed(33'(j));
      end
      ST_CO3: begin
        mul_a = $signed(33'(aa));
        mul_b = $signed(33'(a_val));
      end
      ST_CO4: begin
        mul_a = $signed(33'(aa));
        mul_b = $signed(33'(j));
      end
      ST_CO5: begin
        mul_a = $signed(33'(tt));
        mul_b = $signed(33'(a_val));
      end
      ST_CO6: begin
        mul_a = $signed(33'(tt));
        mul_b = $signed(33'(j));
      end
      ST_MAC_MUL: begin
        mul_a = $signed(33'(coef[m[1:0]]));
        mul_b = m[2] ? 33'(seg_y[0]) : 33'(seg_x[0]);
      end
      default: begin
        mul_a = '0;
        mul_b = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= mul_a * mul_b;
  end

  // Recurrence unit commands
  always_comb begin
    rec_cmd = '0;
    case (state)
      ST_ROOT_GO: begin
        rec_cmd.start     = 1'b1;
        rec_cmd.sqrt_mode = 1'b1;
        rec_cmd.steps     = SQRT_STEPS;
        rec_cmd.acc_init  = ACC_W'(65'(sqx) + 65'(prod[63:0]));
      end
      ST_NCNT: begin
        if ((spacing != '0) && !n_sat) begin
          rec_cmd.start    = 1'b1;
          rec_cmd.steps    = NDIV_STEPS;
          rec_cmd.rem_init = REM_W'(n_num[35:NBITS]);
          rec_cmd.acc_init = {n_num[NBITS-1:0], (ACC_W-NBITS)'(0)};
          rec_cmd.den      = n_den;
        end
      end
      ST_DIV_GO: begin
        rec_cmd.start    = 1'b1;
        rec_cmd.steps    = QDIV_STEPS;
        rec_cmd.rem_init = REM_W'(div_num[49:32]);
        rec_cmd.acc_init = {div_num[31:0], (ACC_W-32)'(0)};
        rec_cmd.den      = ROOT_W'(den);
      end
      default: begin
        rec_cmd = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state   <= ST_IDLE;
      count   <= '0;
      phase   <= '0;
      spacing <= SPACING_RESET;
      limit   <= LIMIT_RESET;
    end else begin
      if (cfg_wen) begin
        case (cfg_index)
          REG_SPACING: spacing <= cfg_data;
          REG_LIMIT:   limit   <= cfg_data[15:0];
          default:     ;
        endcase
      end

      // rotate the segment points so taps 0 and 1 walk the control polygon
      if (rotate) begin
        for (int i = 0; i < 3; i++) begin
          seg_x[i] <= seg_x[i+1];
          seg_y[i] <= seg_y[i+1];
        end
        seg_x[3] <= seg_x[0];
        seg_y[3] <= seg_y[0];
      end

      case (state)
        ST_IDLE: begin
          if (in_valid) begin
            if (count < 16'd3) begin
              held_x[count[1:0]] <= point_x;
              held_y[count[1:0]] <= point_y;
              if (path_end) begin
                pidx  <= '0;
                plast <= count[1:0];
                state <= ST_PASS;
              end
            end else if (count < eff_limit) begin
              if (phase == 2'd0) begin
                for (int i = 0; i < 3; i++) begin
                  seg_x[i] <= held_x[i];
                  seg_y[i] <= held_y[i];
                end
                seg_x[3]  <= point_x;
                seg_y[3]  <= point_y;
                held_x[0] <= point_x;
                held_y[0] <= point_y;
                len       <= '0;
                sidx      <= '0;
                state     <= ST_SQX;
              end else begin
                held_x[phase] <= point_x;
                held_y[phase] <= point_y;
              end
            end
            if (path_end) begin
              count <= '0;
              phase <= '0;
            end else if (count != 16'hFFFF) begin
              count <= count + 16'd1;
              phase <= (phase == 2'd2) ? 2'd0 : phase + 2'd1;
            end
          end
        end
        ST_PASS: begin
          if (out_ready) begin
            if (pidx == plast) begin
              state <= ST_IDLE;
            end else begin
              pidx <= pidx + 2'd1;
            end
          end
        end
        ST_SQX: state <= ST_SQY;
        ST_SQY: begin
          sqx   <= prod[63:0];
          state <= ST_ROOT_GO;
        end
        ST_ROOT_GO: state <= ST_ROOT_WAIT;
        ST_ROOT_WAIT: begin
          if (rec_done) begin
            len <= len + 35'(rec_result);
            if (sidx == 2'd2) begin
              state <= ST_NCNT;
            end else begin
              sidx  <= sidx + 2'd1;
              state <= ST_SQX;
            end
          end
        end
        ST_NCNT: begin
          j <= '0;
          if ((spacing == '0) || n_sat) begin
            n     <= NBITS'(MAX_SAMPLES);
            state <= ST_CO1;
          end else begin
            state <= ST_NWAIT;
          end
        end
        ST_NWAIT: begin
          if (rec_done) begin
            if (q6 == '0) begin
              n <= NBITS'(1);
            end else if (q6 > NBITS'(MAX_SAMPLES)) begin
              n <= NBITS'(MAX_SAMPLES);
            end else begin
              n <= q6;
            end
            state <= ST_CO1;
          end
        end
        ST_CO1: state <= ST_CO2;
        ST_CO2: begin
          aa    <= prod[11:0];
          state <= ST_CO3;
        end
        ST_CO3: begin
          tt    <= prod[11:0];
          state <= ST_CO4;
        end
        ST_CO4: begin
          coef[0] <= prod[17:0];
          // the first sample's a^3 is n^3, the common denominator
          if (j == '0) begin
            den <= prod[17:0];
          end
          state <= ST_CO5;
        end
        ST_CO5: begin
          coef[1] <= 18'({prod[17:0], 1'b0} + 19'(prod[17:0]));
          state   <= ST_CO6;
        end
        ST_CO6: begin
          coef[2] <= 18'({prod[17:0], 1'b0} + 19'(prod[17:0]));
          state   <= ST_CO7;
        end
        ST_CO7: begin
          coef[3] <= prod[17:0];
          acc     <= '0;
          m       <= '0;
          state   <= ST_MAC_MUL;
        end
        ST_MAC_MUL: state <= ST_MAC_ADD;
        ST_MAC_ADD: begin
          acc <= acc + $signed(prod[49:0]);
          m   <= m + 3'd1;
          state <= (m[1:0] == 2'd3) ? ST_DIV_GO : ST_MAC_MUL;
        end
        ST_DIV_GO: begin
          neg   <= acc[49];
          state <= ST_DIV_WAIT;
        end
        ST_DIV_WAIT: begin
          if (rec_done) begin
            if (m[2]) begin
              res_x <= signed_q;
              acc   <= '0;
              state <= ST_MAC_MUL;
            end else begin
              res_y <= signed_q;
              state <= ST_OUT;
            end
          end
        end
        ST_OUT: begin
          if (out_ready) begin
            if (j == n) begin
              state <= ST_IDLE;
            end else begin
              j     <= j + NBITS'(1);
              state <= ST_CO1;
            end
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

### src/bps_checker.sv
// bps_checker: port-level assertions for bezier_path_sampler, bound to the top level.
// Depends only on the top level's ports.
module bps_checker (
  input logic               clk,
  input logic               rst,
  input logic               in_ready,
  input logic               out_valid,
  input logic               out_ready,
  input logic signed [31:0] sample_x,
  input logic signed [31:0] sample_y,
  input logic               run_last
);

  // hold a stalled result
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(sample_x) && $stable(sample_y)
      && $stable(run_last))
    else $error("result changed while stalled");

  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    !(in_ready && out_valid))
    else $error("input taken while results pending");

  a_reset_idle: assert property (@(posedge clk)
    rst |=> !out_valid && in_ready)
    else $error("not idle after reset");

  // more results of the same run keep the input side closed
  a_run_busy: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_ready && !run_last |=> !in_ready)
    else $error("run ended early");

endmodule

bind bezier_path_sampler bps_checker u_bps_checker (.*);
